// ===== rtl/sosc_pkg.sv =====
// package for the substring occurrence counter
// payload structs, configuration register codes and parameter defaults; no dependencies
`default_nettype none

package sosc_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int MAX_LENGTH_DEF  = 65535;

    typedef enum logic [1:0] {
        CFG_PAT_LO  = 2'd0,
        CFG_PAT_HI  = 2'd1,
        CFG_PAT_LEN = 2'd2,
        CFG_WANTED  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0] match_count;
        logic        wanted_found;
        logic [15:0] wanted_position;
        logic        length_overflow;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/substring_occurrence_counter_top.sv =====
// top level of the substring occurrence counter
// depends on sosc_pkg for payload structs, register codes and parameter defaults
`default_nettype none

// Usage:
//   input channel (i_in_valid / o_in_stall / i_in) carries one source byte per
//   transaction with a last-byte mark. output channel (o_out_valid / i_out_stall /
//   o_out) carries one result per string, produced by the transaction that holds
//   the last byte.
//   configuration channel (i_cfg_valid / o_cfg_ready) writes the pattern words,
//   the pattern length and the wanted occurrence; it is always ready.
//   throughput: one byte per cycle while o_in_stall is low. the window compare, the
//   block counter and the count update all settle combinationally between
//   acceptance and the state and result registers.
//   latency: the result is valid in the cycle after the last byte is accepted.
//   stall: while a result waits under i_out_stall, bytes without the last mark are
//   still accepted; a last byte is held off until the result register frees up.
//   reset (synchronous, active low) clears the window, the counters and the
//   result valid flag and restores the register defaults; no clearing pass is needed.
module substring_occurrence_counter_top #(
    parameter int PATTERN_MAX = sosc_pkg::PATTERN_MAX_DEF,
    parameter int MAX_LENGTH  = sosc_pkg::MAX_LENGTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire sosc_pkg::t_in_item  i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output sosc_pkg::t_out_item      o_out,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire sosc_pkg::t_cfg_idx  i_cfg_index,
    input  wire logic [63:0]         i_cfg_data
);
    import sosc_pkg::*;

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int BW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [63:0]  r_pat_lo;
    logic [63:0]  r_pat_hi;
    logic [4:0]   r_pat_len;
    logic [15:0]  r_wanted;

    logic [7:0]   r_win [PATTERN_MAX];
    logic [15:0]  r_pos;
    logic [15:0]  r_count;
    logic [BW-1:0] r_blk;
    logic         r_found;
    logic [15:0]  r_start;
    logic         r_ovf;
    logic         r_out_valid;
    t_out_item    r_out;

    logic [7:0]   n_win [PATTERN_MAX];
    logic [15:0]  n_pos;
    logic [15:0]  n_count;
    logic [BW-1:0] n_blk;
    logic         n_found;
    logic [15:0]  n_start;
    logic         n_ovf;
    logic         n_out_valid;
    t_out_item    n_out;

    logic [7:0]   w [PATTERN_MAX];
    logic [127:0] pat_all;
    logic [LW-1:0] len;
    logic [BW-1:0] blk_cur;
    logic         hit;
    logic         in_acc;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    // only a last byte needs the result register
    assign o_in_stall  = r_out_valid & i_out_stall & i_in.last_byte;
    assign in_acc      = i_in_valid & ~o_in_stall;
    assign pat_all     = {r_pat_hi, r_pat_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= 5'd1;
            r_wanted  <= 16'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PAT_LO:  r_pat_lo  <= i_cfg_data;
                CFG_PAT_HI:  r_pat_hi  <= i_cfg_data;
                CFG_PAT_LEN: r_pat_len <= i_cfg_data[4:0];
                CFG_WANTED:  r_wanted  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        // effective length, clamped to 1..PATTERN_MAX
        if (r_pat_len == 5'd0) begin
            len = LW'(1);
        end else if (r_pat_len > 5'(PATTERN_MAX)) begin
            len = LW'(PATTERN_MAX);
        end else begin
            len = LW'(r_pat_len);
        end

        blk_cur = (r_pos == 16'd0) ? BW'(len - LW'(1)) : r_blk;

        // window after the shift, newest byte in slot 0
        w[0] = i_in.source_byte;
        for (int j = 1; j < PATTERN_MAX; j++) begin
            w[j] = r_win[j-1];
        end

        hit = 1'b1;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if (LW'(k) < len) begin
                if (w[BW'(len - LW'(1) - LW'(k))] != pat_all[8*k +: 8]) begin
                    hit = 1'b0;
                end
            end
        end

        n_win       = r_win;
        n_pos       = r_pos;
        n_count     = r_count;
        n_blk       = r_blk;
        n_found     = r_found;
        n_start     = r_start;
        n_ovf       = r_ovf;
        n_out       = r_out;
        n_out_valid = r_out_valid & i_out_stall;

        if (in_acc) begin
            if (r_pos >= 16'(MAX_LENGTH)) begin
                n_ovf = 1'b1;
            end else begin
                n_win = w;
                if (blk_cur != '0) begin
                    n_blk = blk_cur - BW'(1);
                end else begin
                    n_blk = blk_cur;
                    if (hit) begin
                        if (r_count != 16'hFFFF) begin
                            n_count = r_count + 16'd1;
                            if (r_wanted != 16'd0 && n_count == r_wanted && !r_found) begin
                                n_found = 1'b1;
                                n_start = r_pos - 16'(len - LW'(1));
                            end
                        end
                        n_blk = BW'(len - LW'(1));
                    end
                end
                n_pos = r_pos + 16'd1;
            end

            if (i_in.last_byte) begin
                n_out_valid         = 1'b1;
                n_out.match_count   = n_count;
                n_out.length_overflow = n_ovf;
                if (r_wanted == 16'd0) begin
                    n_out.wanted_found    = 1'b1;
                    n_out.wanted_position = 16'd0;
                end else begin
                    n_out.wanted_found    = n_found;
                    n_out.wanted_position = n_found ? n_start : 16'd0;
                end
                // start the next string from scratch
                for (int j = 0; j < PATTERN_MAX; j++) begin
                    n_win[j] = 8'd0;
                end
                n_pos   = 16'd0;
                n_count = 16'd0;
                n_blk   = BW'(len - LW'(1));
                n_found = 1'b0;
                n_start = 16'd0;
                n_ovf   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < PATTERN_MAX; j++) begin
                r_win[j] <= 8'd0;
            end
            r_pos       <= '0;
            r_count     <= '0;
            r_blk       <= '0;
            r_found     <= 1'b0;
            r_start     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_win       <= n_win;
            r_pos       <= n_pos;
            r_count     <= n_count;
            r_blk       <= n_blk;
            r_found     <= n_found;
            r_start     <= n_start;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

`ifndef SYNTHESIS
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(in_acc && i_in.last_byte))
        else $error("result appeared without a last byte");

    a_found_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_count != 16'd0))
        else $error("wanted occurrence marked found with zero count");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= 16'(MAX_LENGTH))
        else $error("byte position ran past the length bound");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.last_byte) |=> (r_pos == 16'd0 && r_count == 16'd0 && !r_ovf))
        else $error("string state not cleared after last byte");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_substring_occurrence_counter_top.sv =====
`timescale 1ns / 1ps
// testbench for substring_occurrence_counter_top: directed and random source strings,
// each string report checked against an in-bench pattern counter; depends on sosc_pkg

module tb_substring_occurrence_counter_top;
    import sosc_pkg::*;

    localparam int WIN          = PATTERN_MAX_DEF;
    localparam int LEN_LIMIT    = MAX_LENGTH_DEF;
    localparam int RANDOM_BYTES = 1450;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    t_cfg_idx    i_cfg_index;
    logic [63:0] i_cfg_data;

    substring_occurrence_counter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // mirrored configuration registers
    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [4:0]  pat_len;
    logic [15:0] wanted_num;

    // per-string counting state
    logic [7:0]  window [WIN];
    int unsigned byte_pos;
    int unsigned hit_count;
    int unsigned block_left;
    int unsigned found_at;
    bit          found;
    bit          overflowed;

    t_out_item   string_reports [$];
    int          errors;
    int          reports_checked;
    int          bytes_sent;
    bit          idle_on;
    bit          stall_quiet;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("tb_substring_occurrence_counter_top NOT OK");
        $finish;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(0, 2);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned active_len();
        if (pat_len == 0) begin
            return 1;
        end
        if (pat_len > WIN) begin
            return WIN;
        end
        return pat_len;
    endfunction

    function automatic logic [7:0] pattern_at(int unsigned k);
        return (k < 8) ? pat_lo[k*8 +: 8] : pat_hi[(k-8)*8 +: 8];
    endfunction

    task automatic clear_string_state();
        foreach (window[k]) begin
            window[k] = 8'h00;
        end
        byte_pos   = 0;
        hit_count  = 0;
        block_left = active_len() - 1;
        found      = 1'b0;
        found_at   = 0;
        overflowed = 1'b0;
    endtask

    task automatic count_pattern_byte(input logic [7:0] b, input logic is_last);
        int unsigned len;
        bit          hit;
        t_out_item   rep;
        len = active_len();
        if (byte_pos >= LEN_LIMIT) begin
            // bytes past the length bound only raise the flag
            overflowed = 1'b1;
        end else begin
            if (byte_pos == 0) begin
                block_left = len - 1;
            end
            for (int k = WIN - 1; k > 0; k--) begin
                window[k] = window[k-1];
            end
            window[0] = b;
            if (block_left > 0) begin
                block_left--;
            end else begin
                hit = 1'b1;
                for (int k = 0; k < len; k++) begin
                    if (window[len-1-k] != pattern_at(k)) begin
                        hit = 1'b0;
                    end
                end
                if (hit) begin
                    if (hit_count < 65535) begin
                        hit_count++;
                        if (wanted_num != 0 && hit_count == wanted_num && !found) begin
                            found    = 1'b1;
                            found_at = (byte_pos - (len - 1)) & 16'hFFFF;
                        end
                    end
                    block_left = len - 1;
                end
            end
            byte_pos++;
        end
        if (is_last) begin
            rep.match_count     = hit_count[15:0];
            rep.wanted_found    = (wanted_num == 0) ? 1'b1 : found;
            rep.wanted_position = (wanted_num == 0 || !found) ? 16'd0 : found_at[15:0];
            rep.length_overflow = overflowed;
            string_reports.push_back(rep);
            clear_string_state();
        end
    endtask

    // called just after a falling edge; valid is left high after the transaction
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        gap = idle_on ? gap_len() : 0;
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_in.source_byte = b;
        i_in.last_byte   = is_last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        count_pattern_byte(b, is_last);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input logic [7:0] text [$]);
        foreach (text[i]) begin
            send_byte(text[i], i == text.size() - 1);
        end
    endtask

    task automatic wait_for_reports();
        i_in_valid = 1'b0;
        while (string_reports.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [4:0] len, input logic [15:0] wanted);
        t_cfg_idx    idx [4];
        logic [63:0] val [4];
        wait_for_reports();
        idx = '{CFG_PAT_LO, CFG_PAT_HI, CFG_PAT_LEN, CFG_WANTED};
        val = '{lo, hi, {59'd0, len}, {48'd0, wanted}};
        i_cfg_valid = 1'b1;
        for (int r = 0; r < 4; r++) begin
            i_cfg_index = idx[r];
            i_cfg_data  = val[r];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (idx[r])
                CFG_PAT_LO:  pat_lo     = val[r];
                CFG_PAT_HI:  pat_hi     = val[r];
                CFG_PAT_LEN: pat_len    = val[r][4:0];
                CFG_WANTED:  wanted_num = val[r][15:0];
                default: begin
                end
            endcase
            @(negedge i_clk);
        end
        i_cfg_valid = 1'b0;
    endtask

    // register defaults: one-byte pattern of zero, first occurrence wanted
    task automatic test_reset_defaults();
        logic [7:0] text [$];
        text = '{8'h00, 8'hFF, 8'h00};
        send_text(text);
    endtask

    task automatic test_pattern_limits();
        logic [7:0] text [$];
        configure('1, '1, 5'd16, 16'd1);
        text = {};
        repeat (16) text.push_back(8'hFF);
        send_text(text);
        // length above the maximum acts as full length; string shorter than the pattern
        configure('1, '1, 5'd31, 16'd65535);
        text = '{8'hFF};
        send_text(text);
        // zero length acts as one; wanted number zero reports position 0
        configure('0, '0, 5'd0, 16'd0);
        text = '{8'h00, 8'h00};
        send_text(text);
    endtask

    task automatic test_overlap_and_wanted();
        logic [7:0] text [$];
        configure(64'h6161, '0, 5'd2, 16'd2);
        text = '{8'h61, 8'h61, 8'h61, 8'h61, 8'h61};
        send_text(text);
    endtask

    task automatic test_random_strings();
        int          sent;
        int          phase_bytes;
        int unsigned eff;
        int          target;
        int          piece;
        int          r;
        logic [7:0]  alpha [4];
        logic [7:0]  pat [WIN];
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  len;
        logic [15:0] wanted;
        logic [7:0]  text [$];
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            foreach (alpha[k]) alpha[k] = 8'($urandom_range(0, 255));
            r = $urandom_range(0, 9);
            if (r < 7) begin
                len = 5'($urandom_range(1, 4));
            end else if (r < 9) begin
                len = 5'($urandom_range(5, 16));
            end else begin
                len = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
            end
            eff = (len == 0) ? 1 : (len > WIN) ? WIN : len;
            // unused pattern bytes stay random and must be ignored
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
            for (int k = 0; k < WIN; k++) begin
                pat[k] = (k < eff) ? alpha[$urandom_range(0, 3)] : 8'($urandom_range(0, 255));
                if (k < 8) lo[k*8 +: 8] = pat[k];
                else hi[(k-8)*8 +: 8] = pat[k];
            end
            r = $urandom_range(0, 9);
            if (r < 6) begin
                wanted = 16'($urandom_range(1, 3));
            end else if (r < 8) begin
                wanted = 16'd0;
            end else if (r == 8) begin
                wanted = 16'hFFFF;
            end else begin
                wanted = 16'($urandom_range(0, 65535));
            end
            configure(lo, hi, len, wanted);
            idle_on     = ($urandom_range(0, 3) != 0);
            stall_quiet = ($urandom_range(0, 3) == 0);
            phase_bytes = 0;
            while (phase_bytes < 120 && sent < RANDOM_BYTES) begin
                target = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 30)
                                                     : $urandom_range(31, 80);
                text = {};
                if ($urandom_range(0, 6) == 0) begin
                    while (text.size() < target) text.push_back(8'($urandom_range(0, 255)));
                end else begin
                    // pattern copies, broken prefixes and filler from the same alphabet
                    while (text.size() < target) begin
                        piece = $urandom_range(0, 9);
                        if (piece < 5) begin
                            for (int k = 0; k < eff; k++) text.push_back(pat[k]);
                        end else if (piece < 7) begin
                            r = $urandom_range(1, eff);
                            for (int k = 0; k < r; k++) text.push_back(pat[k]);
                        end else begin
                            repeat ($urandom_range(1, 3)) text.push_back(alpha[$urandom_range(0, 3)]);
                        end
                    end
                    while (text.size() > target) void'(text.pop_back());
                end
                send_text(text);
                phase_bytes += text.size();
                sent        += text.size();
            end
        end
        stall_quiet = 1'b0;
        idle_on     = 1'b1;
    endtask

    // receiver stall bursts
    initial begin
        int n;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            n = stall_quiet ? 0 : gap_len();
            if (n > 0) begin
                i_out_stall = 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (string_reports.size() == 0) begin
                $error("result with no string pending: match_count %0d", o_out.match_count);
                errors++;
            end else begin
                want = string_reports.pop_front();
                reports_checked++;
                if (o_out.match_count !== want.match_count) begin
                    $error("match_count: expected %0d, got %0d",
                           want.match_count, o_out.match_count);
                    errors++;
                end
                if (o_out.wanted_found !== want.wanted_found) begin
                    $error("wanted_found: expected %0d, got %0d",
                           want.wanted_found, o_out.wanted_found);
                    errors++;
                end
                if (o_out.wanted_position !== want.wanted_position) begin
                    $error("wanted_position: expected %0d, got %0d",
                           want.wanted_position, o_out.wanted_position);
                    errors++;
                end
                if (o_out.length_overflow !== want.length_overflow) begin
                    $error("length_overflow: expected %0d, got %0d",
                           want.length_overflow, o_out.length_overflow);
                    errors++;
                end
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_in            = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_PAT_LO;
        i_cfg_data      = '0;
        idle_on         = 1'b1;
        stall_quiet     = 1'b0;
        errors          = 0;
        reports_checked = 0;
        bytes_sent      = 0;
        pat_lo          = '0;
        pat_hi          = '0;
        pat_len         = 5'd1;
        wanted_num      = 16'd1;
        clear_string_state();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_pattern_limits();
        test_overlap_and_wanted();
        test_random_strings();

        wait_for_reports();
        repeat (5) @(negedge i_clk);
        $display("summary: %0d source bytes sent, %0d string reports checked", bytes_sent,
                 reports_checked);
        $display("covered register defaults, length limits, overlap blocking, random patterns");
        if (errors == 0) begin
            $display("tb_substring_occurrence_counter_top OK");
        end else begin
            $display("tb_substring_occurrence_counter_top NOT OK");
        end
        $finish;
    end

endmodule
